[src/mng_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mng_pkg
// Types, codes and widths shared by the mesh normal generator modules.
// ----------------------------------------------------------------------------
package mng_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_MAX_FACES    = 65536;

    localparam int IDX_W   = 12;
    localparam int POS_W   = 20;
    localparam int EDGE_W  = 21;
    localparam int PROD_W  = 42;
    localparam int VEC_W   = 44;
    localparam int ACC_W   = 24;
    localparam int NORM_W  = 16;
    localparam int ITEM_W  = 16;
    localparam int MAG_W   = 30;
    localparam int SUM_W   = 62;
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 35;
    localparam int DIV_W   = 32;
    localparam int NUM_W   = 46;
    localparam int QUO_W   = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [QUO_W-1:0] UNIT_ONE = 16'd16384;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;
    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_FACE   = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FACE  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                         cmd;
        logic [IDX_W-1:0]             idx;
        logic                         idx_ok;
        logic [POS_W-1:0]             pos_x;
        logic [POS_W-1:0]             pos_y;
        logic [POS_W-1:0]             pos_z;
        logic [2:0][IDX_W-1:0]        corner;
        logic [2:0]                   corner_ok;
    } t_entry;

    typedef struct packed {
        logic                         kind;
        logic [ITEM_W-1:0]            item;
        logic [2:0][NORM_W-1:0]       norm;
        logic                         deg;
    } t_result;

    typedef struct packed {
        logic                         done;
        logic                         deg;
        logic [2:0][NORM_W-1:0]       u;
    } t_unit_res;

    typedef enum logic [3:0] {
        B_CLR, B_IDLE, B_WRITE, B_PRD, B_EDGE, B_MUL, B_UGO, B_UNIT,
        B_OUT, B_ARD, B_AWR, B_RRD, B_RCAP
    } t_bstate;

    typedef enum logic [2:0] {
        U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_DSET, U_DIV
    } t_ustate;

endpackage

[src/mng_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mng_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/mng_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mng_front
// Input side: unpack a transfer, decode the command, range-check indexes.
// ----------------------------------------------------------------------------
module mng_front import mng_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic         i_tvalid,
    output logic         o_tready,
    input  logic [111:0] i_tdata,
    input  logic [1:0]   i_tuser,
    input  logic         i_q_full,
    input  logic         i_init_busy,
    output logic         o_push,
    output t_entry       o_entry
);
    logic [2:0][IDX_W-1:0] w_corner;

    assign w_corner[0] = i_tdata[83:72];
    assign w_corner[1] = i_tdata[95:84];
    assign w_corner[2] = i_tdata[107:96];

    assign o_tready = !i_q_full && !i_init_busy;
    assign o_push   = i_tvalid && o_tready;

    always_comb begin
        o_entry.cmd    = t_cmd'(i_tuser);
        o_entry.idx    = i_tdata[11:0];
        o_entry.idx_ok = 32'(i_tdata[11:0]) < MAX_VERTICES;
        o_entry.pos_x  = i_tdata[31:12];
        o_entry.pos_y  = i_tdata[51:32];
        o_entry.pos_z  = i_tdata[71:52];
        o_entry.corner = w_corner;
        for (int k = 0; k < 3; k++) begin
            o_entry.corner_ok[k] = 32'(w_corner[k]) < MAX_VERTICES;
        end
    end
endmodule

[src/mng_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mng_queue
// Short command queue between the input side and the sequencer.
// ----------------------------------------------------------------------------
module mng_queue import mng_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_entry        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

[src/mng_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mng_unit
// Normalize unit: prescale, sum of squares, bit-serial square root and
// three restoring divisions to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
module mng_unit import mng_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0][VEC_W-1:0] i_vec,
    output t_unit_res             o_res
);
    t_ustate               r_state;
    t_ustate               n_state;
    logic [VEC_W-1:0]      r_mag [3];
    logic [2:0]            r_neg;
    logic [2*MAG_W-1:0]    r_prod;
    logic [SUM_W-1:0]      r_sum;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [4:0]            r_cnt;
    logic [1:0]            r_k;
    logic [DIV_W-1:0]      r_drem;
    logic [QUO_W-1:0]      r_num_lo;
    logic [QUO_W-1:0]      r_q;
    logic [NORM_W-1:0]     r_u [3];
    logic                  r_deg;
    logic                  r_done;

    logic                  w_zero;
    logic                  w_big;
    logic [1:0]            w_sq_sel;
    logic [REM_W-1:0]      w_trem;
    logic [REM_W-1:0]      w_trial;
    logic                  w_rbit;
    logic [NUM_W-1:0]      w_num;
    logic [DIV_W:0]        w_tdiv;
    logic [DIV_W:0]        w_dsr;
    logic                  w_qbit;
    logic [QUO_W-1:0]      w_qfin;
    logic [QUO_W-1:0]      w_qsat;

    always_comb begin
        w_zero = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);
        w_big  = (|r_mag[0][VEC_W-1:MAG_W]) || (|r_mag[1][VEC_W-1:MAG_W])
              || (|r_mag[2][VEC_W-1:MAG_W]);
        w_sq_sel = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
        w_trem  = {r_rem[REM_W-3:0], r_sum[SUM_W-1:SUM_W-2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_rbit  = w_trem >= w_trial;
        w_num   = NUM_W'({r_mag[r_k][MAG_W-1:0], 15'd0}) + NUM_W'(r_root);
        w_tdiv  = {r_drem, r_num_lo[QUO_W-1]};
        w_dsr   = {1'b0, r_root, 1'b0};
        w_qbit  = w_tdiv >= w_dsr;
        w_qfin  = {r_q[QUO_W-2:0], w_qbit};
        w_qsat  = (w_qfin > UNIT_ONE) ? UNIT_ONE : w_qfin;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE:  if (i_start && !w_zero) n_state = U_SHIFT;
            U_SHIFT: if (!w_big) n_state = U_SQ;
            U_SQ:    if (r_cnt == 5'd3) n_state = U_SQRT;
            U_SQRT:  if (r_cnt == 5'(ROOT_W-1)) n_state = U_DSET;
            U_DSET:  n_state = U_DIV;
            U_DIV: begin
                if (r_cnt == 5'(QUO_W-1)) begin
                    n_state = (r_k == 2'd2) ? U_IDLE : U_DSET;
                end
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == U_IDLE && i_start && w_zero)
                    || (r_state == U_DIV && r_cnt == 5'(QUO_W-1) && r_k == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= i_vec[i][VEC_W-1];
                        r_mag[i] <= i_vec[i][VEC_W-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
                        r_u[i]   <= '0;
                    end
                    r_deg <= w_zero;
                end
            end
            U_SHIFT: begin
                if (w_big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end else begin
                    r_cnt <= '0;
                    r_sum <= '0;
                end
            end
            U_SQ: begin
                r_prod <= r_mag[w_sq_sel][MAG_W-1:0] * r_mag[w_sq_sel][MAG_W-1:0];
                if (r_cnt != 5'd0) begin
                    r_sum <= r_sum + SUM_W'(r_prod);
                end
                if (r_cnt == 5'd3) begin
                    r_cnt  <= '0;
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            U_SQRT: begin
                r_rem  <= w_rbit ? (w_trem - w_trial) : w_trem;
                r_root <= {r_root[ROOT_W-2:0], w_rbit};
                r_sum  <= r_sum << 2;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 5'(ROOT_W-1)) begin
                    r_k <= '0;
                end
            end
            U_DSET: begin
                r_drem   <= DIV_W'(w_num[NUM_W-1:QUO_W]);
                r_num_lo <= w_num[QUO_W-1:0];
                r_q      <= '0;
                r_cnt    <= '0;
            end
            U_DIV: begin
                r_drem   <= w_qbit ? DIV_W'(w_tdiv - w_dsr) : w_tdiv[DIV_W-1:0];
                r_num_lo <= r_num_lo << 1;
                r_q      <= w_qfin;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == 5'(QUO_W-1)) begin
                    r_u[r_k] <= r_neg[r_k] ? (~w_qsat + 1'b1) : w_qsat;
                    r_k      <= r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.done = r_done;
        o_res.deg  = r_deg;
        for (int i = 0; i < 3; i++) begin
            o_res.u[i] = r_u[i];
        end
    end
endmodule

[src/mng_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mng_back
// Command sequencer: vertex and accumulator stores, cross product,
// accumulation, clearing sweep and result register.
// ----------------------------------------------------------------------------
module mng_back import mng_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_FACES    = DEF_MAX_FACES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_mode,
    input  logic    i_empty,
    input  t_entry  i_entry,
    output logic    o_pop,
    output logic    o_init_busy,
    input  logic    i_tready,
    output logic    o_tvalid,
    output t_result o_result
);
    localparam int AW = $clog2(MAX_VERTICES);

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [NORM_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + (ACC_W+1)'($signed(b));
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    t_bstate                  r_state;
    t_bstate                  n_state;
    logic                     r_init;
    t_entry                   r_ent;
    logic [2:0]               r_cnt;
    logic [AW-1:0]            r_addr;
    logic signed [POS_W-1:0]  r_p [3][3];
    logic signed [EDGE_W-1:0] r_e0 [3];
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VEC_W-1:0]  r_cr [3];
    logic [ITEM_W-1:0]        r_face_cnt;
    logic                     r_out_valid;
    t_result                  r_out;

    logic                     w_pos_we;
    logic [AW-1:0]            w_pos_waddr;
    logic [3*POS_W-1:0]       w_pos_wdata;
    logic [AW-1:0]            w_pos_raddr;
    logic [3*POS_W-1:0]       w_pos_rdata;
    logic                     w_acc_we;
    logic [AW-1:0]            w_acc_waddr;
    logic [3*ACC_W-1:0]       w_acc_wdata;
    logic [AW-1:0]            w_acc_raddr;
    logic [3*ACC_W-1:0]       w_acc_rdata;
    logic                     w_ustart;
    t_unit_res                w_ures;
    logic [2:0][VEC_W-1:0]    w_uvec;
    logic [1:0]               w_k;
    logic [1:0]               w_pk;
    logic [2:0]               w_mi;
    logic signed [EDGE_W-1:0] w_ma;
    logic signed [EDGE_W-1:0] w_mb;
    logic                     w_slot_free;
    logic                     w_face_out;
    logic                     w_clr_last;
    logic [ITEM_W:0]          w_face_inc;

    mng_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (w_pos_waddr),
        .i_wdata (w_pos_wdata),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    mng_ram #(.WIDTH(3*ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (w_acc_waddr),
        .i_wdata (w_acc_wdata),
        .i_raddr (w_acc_raddr),
        .o_rdata (w_acc_rdata)
    );

    mng_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ustart),
        .i_vec   (w_uvec),
        .o_res   (w_ures)
    );

    always_comb begin
        w_k         = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
        w_pk        = r_cnt[1:0] - 2'd1;
        w_mi        = r_cnt - 3'd1;
        w_slot_free = !r_out_valid || i_tready;
        w_face_out  = (r_ent.cmd == CMD_FACE) && (i_mode == MODE_FACE);
        w_clr_last  = r_addr == AW'(MAX_VERTICES - 1);
        w_face_inc  = {1'b0, r_face_cnt} + 1'b1;
        for (int i = 0; i < 3; i++) begin
            w_uvec[i] = r_cr[i];
        end
        unique case (r_cnt)
            3'd0:    begin w_ma = r_e0[1]; w_mb = r_e1[2]; end
            3'd1:    begin w_ma = r_e0[2]; w_mb = r_e1[1]; end
            3'd2:    begin w_ma = r_e0[2]; w_mb = r_e1[0]; end
            3'd3:    begin w_ma = r_e0[0]; w_mb = r_e1[2]; end
            3'd4:    begin w_ma = r_e0[0]; w_mb = r_e1[1]; end
            3'd5:    begin w_ma = r_e0[1]; w_mb = r_e1[0]; end
            default: begin w_ma = '0;      w_mb = '0;      end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLR:   if (w_clr_last) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_empty) begin
                    unique case (i_entry.cmd)
                        CMD_CLEAR: n_state = B_CLR;
                        CMD_WRITE: n_state = B_WRITE;
                        CMD_FACE:  n_state = B_PRD;
                        CMD_READ:  n_state = B_RRD;
                        default:   n_state = B_IDLE;
                    endcase
                end
            end
            B_WRITE: n_state = B_IDLE;
            B_PRD:   if (r_cnt == 3'd3) n_state = B_EDGE;
            B_EDGE:  n_state = B_MUL;
            B_MUL:   if (r_cnt == 3'd6) n_state = B_UGO;
            B_UGO:   n_state = B_UNIT;
            B_UNIT: begin
                if (w_ures.done) begin
                    n_state = (r_ent.cmd == CMD_FACE && !w_face_out) ? B_ARD : B_OUT;
                end
            end
            B_OUT:   if (w_slot_free) n_state = B_IDLE;
            B_ARD:   n_state = B_AWR;
            B_AWR:   n_state = (r_cnt == 3'd2) ? B_IDLE : B_ARD;
            B_RRD:   n_state = B_RCAP;
            B_RCAP:  n_state = B_UGO;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        w_ustart    = 1'b0;
        w_pos_we    = 1'b0;
        w_pos_waddr = AW'(r_ent.idx);
        w_pos_wdata = {r_ent.pos_z, r_ent.pos_y, r_ent.pos_x};
        w_pos_raddr = AW'(r_ent.corner[w_k]);
        w_acc_we    = 1'b0;
        w_acc_waddr = r_addr;
        w_acc_wdata = '0;
        w_acc_raddr = AW'(r_ent.corner[w_k]);
        unique case (r_state)
            B_CLR:   w_acc_we = 1'b1;
            B_IDLE:  o_pop = !i_empty;
            B_WRITE: w_pos_we = r_ent.idx_ok;
            B_UGO:   w_ustart = 1'b1;
            B_AWR: begin
                w_acc_we    = r_ent.corner_ok[w_k];
                w_acc_waddr = AW'(r_ent.corner[w_k]);
                for (int i = 0; i < 3; i++) begin
                    w_acc_wdata[i*ACC_W +: ACC_W] =
                        sat_add(w_acc_rdata[i*ACC_W +: ACC_W], w_ures.u[i]);
                end
            end
            B_RRD:   w_acc_raddr = AW'(r_ent.idx);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_face_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLR: begin
                    r_face_cnt <= '0;
                    if (w_clr_last) begin
                        r_init <= 1'b0;
                        r_addr <= '0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                B_OUT: begin
                    if (w_slot_free && w_face_out) begin
                        r_face_cnt <= (w_face_inc >= (ITEM_W+1)'(MAX_FACES))
                                    ? '0 : w_face_inc[ITEM_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_ent <= i_entry;
                r_cnt <= '0;
            end
            B_PRD: begin
                if (r_cnt != 3'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_p[w_pk][i] <= r_ent.corner_ok[w_pk]
                                      ? w_pos_rdata[i*POS_W +: POS_W] : '0;
                    end
                end
                r_cnt <= r_cnt + 1'b1;
            end
            B_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e0[i] <= EDGE_W'(r_p[1][i]) - EDGE_W'(r_p[0][i]);
                    r_e1[i] <= EDGE_W'(r_p[2][i]) - EDGE_W'(r_p[0][i]);
                end
                r_cnt <= '0;
            end
            B_MUL: begin
                r_prod <= w_ma * w_mb;
                if (r_cnt != 3'd0) begin
                    if (!w_mi[0]) begin
                        r_cr[w_mi[2:1]] <= VEC_W'(r_prod);
                    end else begin
                        r_cr[w_mi[2:1]] <= r_cr[w_mi[2:1]] - VEC_W'(r_prod);
                    end
                end
                r_cnt <= r_cnt + 1'b1;
            end
            B_UNIT: r_cnt <= '0;
            B_OUT: begin
                if (w_slot_free) begin
                    r_out.kind <= w_face_out ? KIND_FACE : KIND_VERTEX;
                    r_out.item <= w_face_out ? r_face_cnt : ITEM_W'(r_ent.idx);
                    r_out.norm <= w_ures.u;
                    r_out.deg  <= w_ures.deg;
                end
            end
            B_AWR: r_cnt <= r_cnt + 1'b1;
            B_RCAP: begin
                for (int i = 0; i < 3; i++) begin
                    r_cr[i] <= r_ent.idx_ok
                             ? VEC_W'($signed(w_acc_rdata[i*ACC_W +: ACC_W])) : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_init_busy = r_init;
    assign o_tvalid    = r_out_valid;
    assign o_result    = r_out;
endmodule

[src/mesh_normal_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_normal_generator
// Vertex store, face normal unit and per-vertex normal accumulation.
// ----------------------------------------------------------------------------
// After reset the block sweeps every entry of the accumulator store and
// accepts no item until that is done; a clear command runs the same sweep.
// A face, in face mode and in vertex mode, and a normal read all pass
// through the normalize unit, which works through a prescale, a sum of
// squares, a bit-serial square root and three divisions; a face adds
// three store reads and six products before that. A vertex write only
// stores the position in the vertex store. A zero-length vector skips
// the normalize steps and is reported as degenerate.
// Commands queue up while one is worked on; a finished result waits in the
// output register, and the sequencer stalls only when the next result is
// ready before the previous one has been taken.
module mesh_normal_generator import mng_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_FACES    = DEF_MAX_FACES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,     // normal_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, pad
    input  logic [111:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // item_index, norm_x, norm_y, norm_z, degenerate, pad
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tuser    // kind
);
    logic    r_normal_mode;
    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    logic    w_init_busy;
    t_entry  w_in_entry;
    t_entry  w_q_entry;
    t_result w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_mode <= MODE_VERTEX;
        end else if (i_cfg_valid) begin
            r_normal_mode <= i_cfg_data;
        end
    end

    mng_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_q_full    (w_full),
        .i_init_busy (w_init_busy),
        .o_push      (w_push),
        .o_entry     (w_in_entry)
    );

    mng_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_q_entry),
        .o_empty (w_empty)
    );

    mng_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_FACES(MAX_FACES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_normal_mode),
        .i_empty     (w_empty),
        .i_entry     (w_q_entry),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_result    (w_result)
    );

    assign m_axis_tuser = w_result.kind;
    assign m_axis_tdata = {7'd0, w_result.deg, w_result.norm[2], w_result.norm[1],
                           w_result.norm[0], w_result.item};

    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> !s_axis_tready)
        else $error("input taken during accumulator sweep");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:16] == 48'd0)
        else $error("degenerate result with nonzero normal");

    a_face_needs_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FACE) |-> r_normal_mode == MODE_FACE)
        else $error("face normal emitted in vertex mode");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[31:16]) <= 16'sd16384)
            && ($signed(m_axis_tdata[31:16]) >= -16'sd16384)
            && ($signed(m_axis_tdata[47:32]) <= 16'sd16384)
            && ($signed(m_axis_tdata[47:32]) >= -16'sd16384)
            && ($signed(m_axis_tdata[63:48]) <= 16'sd16384)
            && ($signed(m_axis_tdata[63:48]) >= -16'sd16384))
        else $error("normal component beyond unit range");
endmodule
